// ===== rtl/core/vlg_pkg.sv =====
// vlg_pkg: types and constants shared by the velocity limit governor
// used by vlg_div and velocity_limit_governor; no dependencies
`default_nettype none

package vlg_pkg;

  // item function codes
  typedef enum logic [1:0] {
    FN_CMD    = 2'd0,
    FN_LIMIT  = 2'd1,
    FN_TICK   = 2'd2,
    FN_ENABLE = 2'd3
  } func_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_TIMEOUT0  = 3'd0,
    REG_TIMEOUT1  = 3'd1,
    REG_TIMEOUT2  = 3'd2,
    REG_TIMEOUT3  = 3'd3,
    REG_STOP_MASK = 3'd4,
    REG_CFG_MASK  = 3'd5,
    REG_WATCHDOG  = 3'd6,
    REG_UNUSED    = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_SAT,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  localparam int unsigned VEL_W          = 16;
  localparam int unsigned AGE_W          = 16;
  localparam int unsigned MASK_W         = 4;
  localparam int unsigned N_TIMEOUT_REGS = 4;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 16;
  // clamp accumulator: wide enough for the negation of the most negative limit
  localparam int unsigned ACC_W          = 18;
  // magnitude of a 16x16 signed product and of a 16-bit signed divisor
  localparam int unsigned DVD_W          = 31;
  localparam int unsigned DVS_W          = 16;

  localparam logic [AGE_W-1:0] AGE_MAX       = '1;
  localparam logic [AGE_W-1:0] WATCHDOG_RST  = 16'd10;
  localparam logic signed [VEL_W-1:0] VEL_MAX = 16'sh7FFF;
  localparam logic signed [VEL_W-1:0] VEL_MIN = 16'sh8000;

endpackage

`default_nettype wire

// ===== rtl/core/velocity_limit_governor.sv =====
// Velocity limit governor: command, limit, enable and tick items in Q4.12; a tick
// yields one limited (linear, angular) item. Command, limit and enable items leave the
// block idle. A tick passes each source in turn through the shared clamp comparator,
// then saturates and multiplies, runs the one-bit-per-cycle divider and loads the
// output; the divider is skipped when either the commanded or the limited linear speed
// is zero. A finished result waits in the output register while further items are
// taken.
// depends on vlg_pkg and vlg_div
`default_nettype none

module velocity_limit_governor #(
  parameter int N_SOURCES = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // item input
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        in_func,
  input  wire logic [1:0]                        in_source_index,
  input  wire logic signed [vlg_pkg::VEL_W-1:0]  in_speed_value,
  input  wire logic signed [vlg_pkg::VEL_W-1:0]  in_turn_value,
  input  wire logic                              in_enable_value,
  // result output
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [vlg_pkg::VEL_W-1:0]       out_linear_out,
  output logic signed [vlg_pkg::VEL_W-1:0]       out_angular_out,
  // register writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [vlg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [vlg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned SRC_IW = (N_SOURCES > 1) ? $clog2(N_SOURCES) : 1;
  localparam logic [SRC_IW-1:0] SRC_LAST = SRC_IW'(N_SOURCES - 1);

  // configuration
  logic [vlg_pkg::AGE_W-1:0]  timeout_r [vlg_pkg::N_TIMEOUT_REGS];
  logic [vlg_pkg::MASK_W-1:0] stop_mask_r;
  logic [vlg_pkg::MASK_W-1:0] cfg_mask_r;
  logic [vlg_pkg::AGE_W-1:0]  watchdog_r;

  // source and command state
  logic signed [vlg_pkg::VEL_W-1:0] src_limit_r [N_SOURCES];
  logic [vlg_pkg::AGE_W-1:0]        src_age_r   [N_SOURCES];
  logic [N_SOURCES-1:0]             src_en_r;
  logic [N_SOURCES-1:0]             stop_vec;
  logic signed [vlg_pkg::VEL_W-1:0] cmd_linear_r;
  logic signed [vlg_pkg::VEL_W-1:0] cmd_angular_r;
  logic [vlg_pkg::AGE_W-1:0]        cmd_age_r;

  // tick datapath
  vlg_pkg::state_t                  state_r, state_nxt;
  logic [SRC_IW-1:0]                src_cnt_r;
  logic signed [vlg_pkg::ACC_W-1:0] l_r;
  logic signed [vlg_pkg::VEL_W-1:0] r_r;
  logic signed [vlg_pkg::VEL_W-1:0] lin_r;
  logic signed [2*vlg_pkg::VEL_W-1:0] prod_w;
  logic signed [vlg_pkg::VEL_W-1:0] ang_r;
  logic                             out_valid_r;
  logic signed [vlg_pkg::VEL_W-1:0] out_lin_r;
  logic signed [vlg_pkg::VEL_W-1:0] out_ang_r;

  logic                             in_acc;
  vlg_pkg::func_t                   func;
  logic [3:0]                       in_src_ext;
  logic [vlg_pkg::AGE_W-1:0]        cmd_age_inc;
  logic                             cmd_stale;
  logic                             out_free;
  logic                             div_start;
  logic                             div_done;
  logic [vlg_pkg::DVD_W-1:0]        div_quo;
  logic [vlg_pkg::DVD_W-1:0]        prod_mag;
  logic [vlg_pkg::DVS_W-1:0]        cmd_mag;
  logic                             quo_neg;
  logic                             skip_div;
  logic signed [vlg_pkg::VEL_W-1:0] ang_sat;

  // clamp step for the source under the counter
  logic signed [vlg_pkg::VEL_W-1:0] lim;
  logic signed [vlg_pkg::ACC_W-1:0] lim_x;
  logic signed [vlg_pkg::ACC_W-1:0] lim_neg;
  logic signed [vlg_pkg::ACC_W-1:0] l_min;
  logic signed [vlg_pkg::ACC_W-1:0] l_clamp;

  assign in_acc     = in_valid && !in_stall;
  assign func       = vlg_pkg::func_t'(in_func);
  assign in_src_ext = {2'b00, in_source_index};
  assign out_free   = !out_valid_r || !out_stall;
  assign cfg_ready  = (state_r == vlg_pkg::ST_IDLE);
  assign in_stall   = (state_r != vlg_pkg::ST_IDLE);

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < vlg_pkg::N_TIMEOUT_REGS; k++) timeout_r[k] <= '0;
      stop_mask_r <= '0;
      cfg_mask_r  <= '0;
      watchdog_r  <= vlg_pkg::WATCHDOG_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (vlg_pkg::reg_idx_t'(cfg_index))
        vlg_pkg::REG_TIMEOUT0:  timeout_r[0] <= cfg_data;
        vlg_pkg::REG_TIMEOUT1:  timeout_r[1] <= cfg_data;
        vlg_pkg::REG_TIMEOUT2:  timeout_r[2] <= cfg_data;
        vlg_pkg::REG_TIMEOUT3:  timeout_r[3] <= cfg_data;
        vlg_pkg::REG_STOP_MASK: stop_mask_r  <= cfg_data[vlg_pkg::MASK_W-1:0];
        vlg_pkg::REG_CFG_MASK:  cfg_mask_r   <= cfg_data[vlg_pkg::MASK_W-1:0];
        vlg_pkg::REG_WATCHDOG:  watchdog_r   <= cfg_data;
        vlg_pkg::REG_UNUSED: ;
      endcase
    end
  end

  // ---------------- per-source state ----------------
  for (genvar i = 0; i < N_SOURCES; i++) begin : g_src
    logic [vlg_pkg::AGE_W-1:0] to;
    logic [vlg_pkg::AGE_W-1:0] age_inc;
    logic                      hit;

    // sources past the timeout registers never expire and have no stop bit
    if (i < vlg_pkg::N_TIMEOUT_REGS) begin : g_to
      assign to          = timeout_r[i];
      assign stop_vec[i] = stop_mask_r[i];
    end else begin : g_no_to
      assign to          = '0;
      assign stop_vec[i] = 1'b0;
    end

    assign age_inc = (src_age_r[i] == vlg_pkg::AGE_MAX) ? vlg_pkg::AGE_MAX
                                                        : src_age_r[i] + 1'b1;
    assign hit     = (in_src_ext == 4'(i));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        src_limit_r[i] <= '0;
        src_age_r[i]   <= '0;
        src_en_r[i]    <= 1'b1;
      end else if (in_acc) begin
        unique case (func)
          vlg_pkg::FN_CMD: ;
          vlg_pkg::FN_LIMIT: begin
            if (hit) begin
              src_limit_r[i] <= in_speed_value;
              src_age_r[i]   <= '0;
            end
          end
          vlg_pkg::FN_TICK: begin
            src_age_r[i] <= age_inc;
            if (to != '0 && age_inc > to) src_limit_r[i] <= '0;
          end
          vlg_pkg::FN_ENABLE: begin
            if (hit && cfg_mask_r[in_source_index]) src_en_r[i] <= in_enable_value;
          end
        endcase
      end
    end
  end

  // ---------------- command state ----------------
  assign cmd_age_inc = (cmd_age_r == vlg_pkg::AGE_MAX) ? vlg_pkg::AGE_MAX
                                                       : cmd_age_r + 1'b1;
  assign cmd_stale   = (cmd_age_inc > watchdog_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_linear_r  <= '0;
      cmd_angular_r <= '0;
      cmd_age_r     <= vlg_pkg::AGE_MAX;
    end else if (in_acc) begin
      unique case (func)
        vlg_pkg::FN_CMD: begin
          cmd_linear_r  <= in_speed_value;
          cmd_angular_r <= in_turn_value;
          cmd_age_r     <= '0;
        end
        vlg_pkg::FN_TICK: begin
          cmd_age_r <= cmd_age_inc;
          if (cmd_stale) begin
            cmd_linear_r  <= '0;
            cmd_angular_r <= '0;
          end
        end
        vlg_pkg::FN_LIMIT, vlg_pkg::FN_ENABLE: ;
      endcase
    end
  end

  // ---------------- shared clamp comparator ----------------
  assign lim     = src_limit_r[src_cnt_r];
  assign lim_x   = vlg_pkg::ACC_W'(lim);
  assign lim_neg = -lim_x;
  assign l_min   = (lim_x < l_r) ? lim_x : l_r;
  assign l_clamp = (l_min < lim_neg) ? lim_neg : l_min;

  // ---------------- divider operands and result ----------------
  // r_r and lin_r hold still from the multiply cycle until the result is loaded
  assign prod_w   = r_r * lin_r;
  assign prod_mag = prod_w[2*vlg_pkg::VEL_W-1] ? vlg_pkg::DVD_W'(-prod_w)
                                               : vlg_pkg::DVD_W'(prod_w);
  assign cmd_mag  = cmd_linear_r[vlg_pkg::VEL_W-1] ? vlg_pkg::DVS_W'(-cmd_linear_r)
                                                   : vlg_pkg::DVS_W'(cmd_linear_r);
  assign quo_neg  = prod_w[2*vlg_pkg::VEL_W-1] ^ cmd_linear_r[vlg_pkg::VEL_W-1];
  assign skip_div = (cmd_linear_r == '0) || (lin_r == '0);

  always_comb begin
    if (quo_neg) begin
      if (div_quo > vlg_pkg::DVD_W'(32768)) ang_sat = vlg_pkg::VEL_MIN;
      else                                  ang_sat = -signed'(div_quo[vlg_pkg::VEL_W-1:0]);
    end else begin
      if (div_quo > vlg_pkg::DVD_W'(32767)) ang_sat = vlg_pkg::VEL_MAX;
      else                                  ang_sat = signed'(div_quo[vlg_pkg::VEL_W-1:0]);
    end
  end

  vlg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_mag),
    .divisor  (cmd_mag),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= vlg_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    unique case (state_r)
      vlg_pkg::ST_IDLE: begin
        if (in_acc && func == vlg_pkg::FN_TICK) state_nxt = vlg_pkg::ST_CLAMP;
      end
      vlg_pkg::ST_CLAMP: begin
        if (src_cnt_r == SRC_LAST) state_nxt = vlg_pkg::ST_SAT;
      end
      vlg_pkg::ST_SAT: state_nxt = vlg_pkg::ST_MUL;
      vlg_pkg::ST_MUL: begin
        if (skip_div) begin
          state_nxt = vlg_pkg::ST_FIN;
        end else begin
          div_start = 1'b1;
          state_nxt = vlg_pkg::ST_DIV;
        end
      end
      vlg_pkg::ST_DIV: begin
        if (div_done) state_nxt = vlg_pkg::ST_FIN;
      end
      vlg_pkg::ST_FIN: begin
        if (out_free) state_nxt = vlg_pkg::ST_IDLE;
      end
      default: state_nxt = vlg_pkg::ST_IDLE;
    endcase
  end

  // tick datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cnt_r <= '0;
    end else if (state_r == vlg_pkg::ST_IDLE) begin
      src_cnt_r <= '0;
    end else if (state_r == vlg_pkg::ST_CLAMP && src_cnt_r != SRC_LAST) begin
      src_cnt_r <= src_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      vlg_pkg::ST_IDLE: begin
        // start from the command as it stands after this tick's watchdog check
        l_r <= cmd_stale ? '0 : vlg_pkg::ACC_W'(cmd_linear_r);
        r_r <= cmd_stale ? '0 : cmd_angular_r;
      end
      vlg_pkg::ST_CLAMP: begin
        if (src_en_r[src_cnt_r]) begin
          l_r <= l_clamp;
          if (lim == '0 && stop_vec[src_cnt_r]) r_r <= '0;
        end
      end
      vlg_pkg::ST_SAT: begin
        if (l_r > vlg_pkg::ACC_W'(vlg_pkg::VEL_MAX))      lin_r <= vlg_pkg::VEL_MAX;
        else if (l_r < vlg_pkg::ACC_W'(vlg_pkg::VEL_MIN)) lin_r <= vlg_pkg::VEL_MIN;
        else                                             lin_r <= l_r[vlg_pkg::VEL_W-1:0];
      end
      vlg_pkg::ST_MUL: begin
        if (skip_div) ang_r <= r_r;
      end
      vlg_pkg::ST_DIV: begin
        if (div_done) ang_r <= ang_sat;
      end
      vlg_pkg::ST_FIN: ;
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == vlg_pkg::ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == vlg_pkg::ST_FIN && out_free) begin
      out_lin_r <= lin_r;
      out_ang_r <= ang_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_linear_out  = out_lin_r;
  assign out_angular_out = out_ang_r;

  // ---------------- assertions ----------------
  a_tick_starts_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && func == vlg_pkg::FN_TICK) |=> state_r == vlg_pkg::ST_CLAMP)
    else $error("tick item did not start the clamp pass");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == vlg_pkg::ST_FIN))
    else $error("result raised outside the final state");

  a_cmd_held_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != vlg_pkg::ST_IDLE && $past(state_r != vlg_pkg::ST_IDLE))
      |-> $stable(cmd_linear_r))
    else $error("command changed while a tick was in progress");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == vlg_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

endmodule

`default_nettype wire

// ===== rtl/core/vlg_div.sv =====
// vlg_div: unsigned restoring divider, one quotient bit per cycle
// depends on vlg_pkg for operand widths
`default_nettype none

module vlg_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [vlg_pkg::DVD_W-1:0]     dividend,
  input  wire logic [vlg_pkg::DVS_W-1:0]     divisor,
  output logic                               done,
  output logic [vlg_pkg::DVD_W-1:0]          quotient
);

  localparam int unsigned CNT_W = $clog2(vlg_pkg::DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(vlg_pkg::DVD_W - 1);

  logic [vlg_pkg::DVD_W-1:0] quo_r;
  logic [vlg_pkg::DVS_W-1:0] rem_r;
  logic [vlg_pkg::DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      busy_r;
  logic                      done_r;

  logic [vlg_pkg::DVS_W:0]   trial;
  logic [vlg_pkg::DVS_W:0]   diff;
  logic                      qbit;

  assign trial = {rem_r, quo_r[vlg_pkg::DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign qbit  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits in DVS_W bits
      rem_r <= qbit ? diff[vlg_pkg::DVS_W-1:0] : trial[vlg_pkg::DVS_W-1:0];
      quo_r <= {quo_r[vlg_pkg::DVD_W-2:0], qbit};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== tb/sv/tb_velocity_limit_governor.sv =====
// tb_velocity_limit_governor: self-checking bench for the velocity limit governor
// drives command, limit, enable and tick items under several register settings and checks
// every tick result against an in-bench predictor; depends on vlg_pkg and the governor rtl
`default_nettype none

module tb_velocity_limit_governor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSRC          = 4;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AT       = 40;
  localparam int QUIET_LIMIT   = 3000;
  localparam int IDLE_PCT      = 29;

  typedef struct {
    vlg_pkg::func_t                   fn;
    logic [1:0]                       src;
    logic signed [vlg_pkg::VEL_W-1:0] speed;
    logic signed [vlg_pkg::VEL_W-1:0] turn;
    logic                             en;
  } gov_item_t;

  typedef struct {
    logic signed [vlg_pkg::VEL_W-1:0] lin;
    logic signed [vlg_pkg::VEL_W-1:0] ang;
  } vel_pair_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [1:0]                       in_func = '0;
  logic [1:0]                       in_source_index = '0;
  logic signed [vlg_pkg::VEL_W-1:0] in_speed_value = '0;
  logic signed [vlg_pkg::VEL_W-1:0] in_turn_value = '0;
  logic                             in_enable_value = 1'b0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic signed [vlg_pkg::VEL_W-1:0] out_linear_out;
  logic signed [vlg_pkg::VEL_W-1:0] out_angular_out;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  vlg_pkg::reg_idx_t                cfg_index = vlg_pkg::REG_TIMEOUT0;
  logic [vlg_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  // predictor copy of the registers
  logic [vlg_pkg::AGE_W-1:0]        gov_timeout [NSRC];
  logic [vlg_pkg::MASK_W-1:0]       gov_stop_mask;
  logic [vlg_pkg::MASK_W-1:0]       gov_cfg_mask;
  logic [vlg_pkg::AGE_W-1:0]        gov_watchdog;
  // predictor copy of the governor state
  logic signed [vlg_pkg::VEL_W-1:0] src_limit [NSRC];
  logic [vlg_pkg::AGE_W-1:0]        src_age [NSRC];
  logic                             src_en [NSRC];
  logic signed [vlg_pkg::VEL_W-1:0] cmd_lin;
  logic signed [vlg_pkg::VEL_W-1:0] cmd_ang;
  logic [vlg_pkg::AGE_W-1:0]        cmd_age;

  gov_item_t pending_items [$];
  vel_pair_t expected_vel [$];
  gov_item_t cur_item;

  bit calm = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int items_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int config_sets = 0;
  int quiet_cycles = 0;

  velocity_limit_governor #(.N_SOURCES(NSRC)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_source_index (in_source_index),
    .in_speed_value  (in_speed_value),
    .in_turn_value   (in_turn_value),
    .in_enable_value (in_enable_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_linear_out  (out_linear_out),
    .out_angular_out (out_angular_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [vlg_pkg::VEL_W-1:0] sat_vel(longint v);
    if (v > 32767) return vlg_pkg::VEL_MAX;
    if (v < -32768) return vlg_pkg::VEL_MIN;
    return v[vlg_pkg::VEL_W-1:0];
  endfunction

  // advance the predicted state by one accepted item, queue the result of a tick
  function automatic void governor_step(gov_item_t it);
    int l;
    int r;
    int lim_i;
    vel_pair_t res;
    case (it.fn)
      vlg_pkg::FN_CMD: begin
        cmd_lin = it.speed;
        cmd_ang = it.turn;
        cmd_age = '0;
      end
      vlg_pkg::FN_LIMIT: begin
        src_limit[it.src] = it.speed;
        src_age[it.src] = '0;
      end
      vlg_pkg::FN_ENABLE: begin
        if (gov_cfg_mask[it.src]) src_en[it.src] = it.en;
      end
      default: begin
        for (int i = 0; i < NSRC; i++) begin
          if (src_age[i] != vlg_pkg::AGE_MAX) src_age[i] = src_age[i] + 1'b1;
          if (gov_timeout[i] != 0 && src_age[i] > gov_timeout[i]) src_limit[i] = '0;
        end
        if (cmd_age != vlg_pkg::AGE_MAX) cmd_age = cmd_age + 1'b1;
        if (cmd_age > gov_watchdog) begin
          cmd_lin = '0;
          cmd_ang = '0;
        end
        l = cmd_lin;
        r = cmd_ang;
        // each enabled limit clamps in turn, a negative limit lands on its negation
        for (int i = 0; i < NSRC; i++) begin
          if (src_en[i]) begin
            lim_i = src_limit[i];
            if (lim_i < l) l = lim_i;
            if (l < -lim_i) l = -lim_i;
            if (lim_i == 0 && gov_stop_mask[i]) r = 0;
          end
        end
        res.lin = sat_vel(l);
        if (cmd_lin != 0 && res.lin != 0)
          res.ang = sat_vel((longint'(r) * longint'(res.lin)) / longint'(cmd_lin));
        else
          res.ang = r[vlg_pkg::VEL_W-1:0];
        expected_vel.insert(expected_vel.size(), res);
      end
    endcase
  endfunction

  function automatic logic signed [vlg_pkg::VEL_W-1:0] rand_vel();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return vlg_pkg::VEL_MAX;
          1: return vlg_pkg::VEL_MIN;
          2: return 16'sd0;
          3: return 16'sd1;
          default: return -16'sd1;
        endcase
      end
      1, 2, 3, 4: begin
        if ($urandom_range(0, 1) != 0) return 16'($urandom_range(0, 8191));
        return -16'($urandom_range(0, 8191));
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [vlg_pkg::AGE_W-1:0] rand_timeout();
    if ($urandom_range(0, 2) == 0) return '0;
    return 16'($urandom_range(1, 30));
  endfunction

  task automatic push_item(vlg_pkg::func_t fn, logic [1:0] src, int speed, int turn,
                           logic en);
    gov_item_t it;
    it.fn = fn;
    it.src = src;
    it.speed = speed[vlg_pkg::VEL_W-1:0];
    it.turn = turn[vlg_pkg::VEL_W-1:0];
    it.en = en;
    pending_items.insert(pending_items.size(), it);
  endtask

  // mostly positive limits, some commands, many ticks; unused fields carry noise
  task automatic queue_random(int count);
    gov_item_t it;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      it.src = 2'($urandom_range(0, 3));
      it.speed = 16'($urandom);
      it.turn = 16'($urandom);
      it.en = 1'($urandom_range(0, 1));
      if (pick < 25) begin
        it.fn = vlg_pkg::FN_CMD;
        it.speed = rand_vel();
        it.turn = rand_vel();
      end else if (pick < 55) begin
        it.fn = vlg_pkg::FN_LIMIT;
        case ($urandom_range(0, 19))
          0, 1, 2: it.speed = rand_vel();
          3, 4, 5: it.speed = 16'($urandom);
          default: it.speed = 16'($urandom_range(0, 32767));
        endcase
      end else if (pick < 90) begin
        it.fn = vlg_pkg::FN_TICK;
      end else begin
        it.fn = vlg_pkg::FN_ENABLE;
        it.en = ($urandom_range(0, 3) != 0);
      end
      pending_items.insert(pending_items.size(), it);
    end
  endtask

  task automatic write_reg(vlg_pkg::reg_idx_t idx, logic [vlg_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      vlg_pkg::REG_TIMEOUT0, vlg_pkg::REG_TIMEOUT1,
      vlg_pkg::REG_TIMEOUT2, vlg_pkg::REG_TIMEOUT3: gov_timeout[idx[1:0]] = val;
      vlg_pkg::REG_STOP_MASK: gov_stop_mask = val[vlg_pkg::MASK_W-1:0];
      vlg_pkg::REG_CFG_MASK:  gov_cfg_mask = val[vlg_pkg::MASK_W-1:0];
      vlg_pkg::REG_WATCHDOG:  gov_watchdog = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    // one quiet cycle so the next write starts in a later time step
    @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] t0, logic [15:0] t1, logic [15:0] t2,
                            logic [15:0] t3, logic [15:0] stop, logic [15:0] cfgm,
                            logic [15:0] wd);
    write_reg(vlg_pkg::REG_TIMEOUT0, t0);
    write_reg(vlg_pkg::REG_TIMEOUT1, t1);
    write_reg(vlg_pkg::REG_TIMEOUT2, t2);
    write_reg(vlg_pkg::REG_TIMEOUT3, t3);
    write_reg(vlg_pkg::REG_STOP_MASK, stop);
    write_reg(vlg_pkg::REG_CFG_MASK, cfgm);
    write_reg(vlg_pkg::REG_WATCHDOG, wd);
    config_sets++;
  endtask

  // wait for every item and result to pass, then let a last item finish inside the block
  task automatic drain_and_settle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_vel.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // item driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        governor_step(cur_item);
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_func <= cur_item.fn;
          in_source_index <= cur_item.src;
          in_speed_value <= cur_item.speed;
          in_turn_value <= cur_item.turn;
          in_enable_value <= cur_item.en;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver stall, with one long hold so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // result checker
  always @(posedge clk) begin
    vel_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_vel.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: linear %0d angular %0d",
                   out_linear_out, out_angular_out);
      end else begin
        want = expected_vel.pop_front();
        if (out_linear_out !== want.lin || out_angular_out !== want.ang) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: linear exp %0d got %0d, angular exp %0d got %0d",
                     results_seen, want.lin, out_linear_out, want.ang, out_angular_out);
        end
      end
    end
  end

  // no handshake on any channel for too long means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", quiet_cycles);
      $display("tb_velocity_limit_governor: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < NSRC; i++) begin
      gov_timeout[i] = '0;
      src_limit[i] = '0;
      src_age[i] = '0;
      src_en[i] = 1'b1;
    end
    gov_stop_mask = '0;
    gov_cfg_mask = '0;
    gov_watchdog = vlg_pkg::WATCHDOG_RST;
    cmd_lin = '0;
    cmd_ang = '0;
    cmd_age = vlg_pkg::AGE_MAX;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items under the reset register values
    push_item(vlg_pkg::FN_TICK, 2'd0, 0, 0, 1'b0);
    push_item(vlg_pkg::FN_ENABLE, 2'd1, 0, 0, 1'b0);       // not configurable, ignored
    push_item(vlg_pkg::FN_CMD, 2'd0, 32767, -32768, 1'b0);
    push_item(vlg_pkg::FN_TICK, 2'd3, 0, 0, 1'b1);         // zero limits everywhere
    push_item(vlg_pkg::FN_LIMIT, 2'd0, 32767, 0, 1'b0);
    push_item(vlg_pkg::FN_LIMIT, 2'd1, -32768, 0, 1'b0);   // most negative limit
    push_item(vlg_pkg::FN_LIMIT, 2'd2, 16384, 0, 1'b0);
    push_item(vlg_pkg::FN_LIMIT, 2'd3, 4096, 0, 1'b0);
    push_item(vlg_pkg::FN_TICK, 2'd0, 0, 0, 1'b0);
    push_item(vlg_pkg::FN_CMD, 2'd0, -32768, 32767, 1'b0);
    push_item(vlg_pkg::FN_TICK, 2'd0, 0, 0, 1'b0);
    push_item(vlg_pkg::FN_LIMIT, 2'd3, -32768, 0, 1'b0);   // ends on +32768, saturates
    push_item(vlg_pkg::FN_CMD, 2'd0, 1, -1, 1'b0);
    push_item(vlg_pkg::FN_TICK, 2'd0, 0, 0, 1'b0);
    push_item(vlg_pkg::FN_CMD, 2'd0, 0, 12345, 1'b0);      // zero linear keeps angular as is
    push_item(vlg_pkg::FN_TICK, 2'd0, 0, 0, 1'b0);
    push_item(vlg_pkg::FN_LIMIT, 2'd1, 0, 0, 1'b0);
    push_item(vlg_pkg::FN_LIMIT, 2'd3, 0, 0, 1'b0);
    push_item(vlg_pkg::FN_CMD, 2'd0, -4096, 8192, 1'b0);
    for (int n = 0; n < 6; n++) push_item(vlg_pkg::FN_TICK, 2'(n), 0, 0, 1'b1);
    drain_and_settle();

    set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'h0, 16'hF, 16'd10);
    queue_random(200);
    drain_and_settle();

    // no idling on either side for this whole stretch
    calm = 1'b1;
    set_config(16'd3, 16'd5, 16'd8, 16'd1, 16'hF, 16'hF, 16'd4);
    queue_random(200);
    drain_and_settle();
    calm = 1'b0;

    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h5, 16'hA, 16'hFFFF);
    write_reg(vlg_pkg::REG_UNUSED, 16'h1234);
    queue_random(200);
    drain_and_settle();

    set_config(16'd1, 16'd1, 16'd1, 16'd1, 16'hFFFF, 16'h0, 16'd1);
    queue_random(200);
    drain_and_settle();

    // watchdog of zero stales the command on every tick
    set_config(16'd2, 16'd0, 16'd20, 16'hFFFF, 16'h3, 16'hC, 16'd0);
    queue_random(150);
    drain_and_settle();

    for (int p = 0; p < 2; p++) begin
      set_config(rand_timeout(), rand_timeout(), rand_timeout(), rand_timeout(),
                 16'($urandom), 16'($urandom), 16'($urandom_range(1, 40)));
      queue_random(250);
      drain_and_settle();
    end

    $display("tb_velocity_limit_governor: %0d items taken, %0d tick results checked",
             items_taken, results_seen);
    $display("tb_velocity_limit_governor: %0d settings, %0d mismatches, %0d results owed",
             config_sets, mismatches, expected_vel.size());
    if (mismatches == 0 && expected_vel.size() == 0)
      $display("tb_velocity_limit_governor: done, clean");
    else
      $display("tb_velocity_limit_governor: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
